// ===== hdl/hsc_pkg.sv =====
package hsc_pkg;

    typedef logic [5:0] reg_id_t;
    typedef logic [2:0] stage_t;

    localparam reg_id_t REG_RA    = 6'd31;
    localparam reg_id_t REG_HILO  = 6'd33;
    localparam reg_id_t REG_EMPTY = 6'd63;

    // pipeline stage numbers (IF1=1 .. MEM2=7)
    localparam stage_t STG_NONE = 3'd0;
    localparam stage_t STG_ID   = 3'd3;
    localparam stage_t STG_EXE1 = 3'd4;
    localparam stage_t STG_EXE2 = 3'd5;
    localparam stage_t STG_MEM2 = 3'd7;

    localparam logic [1:0] FLUSH_NONE = 2'd0;
    localparam logic [1:0] FLUSH_CTL  = 2'd2;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_TRAP    = 6'h1a;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2b;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_MFHI = 6'h10;
    localparam logic [5:0] FN_MFLO = 6'h12;
    localparam logic [5:0] FN_MULT = 6'h18;
    localparam logic [5:0] FN_DIV  = 6'h1a;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_SLT  = 6'h2a;

    localparam logic [3:0] TRAP_HALT = 4'h0;
    localparam logic [3:0] TRAP_PUTI = 4'h1;
    localparam logic [3:0] TRAP_GETI = 4'h5;
    localparam logic [3:0] TRAP_NOP  = 4'ha;

    localparam logic [31:0] PIPE_FILL = 32'd7;

    typedef struct packed {
        reg_id_t    src0;
        reg_id_t    src1;
        stage_t     need0;
        stage_t     need1;
        logic [1:0] nsrc;
        logic       push;
        reg_id_t    dest;
        stage_t     ready;
        logic [1:0] flush;
        logic       unsup;
    } dec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BUBBLE,
        ST_PUSH,
        ST_SUM,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/hsc_in_if.sv =====
interface hsc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr_word;
    logic        branch_taken;
    logic        divisor_zero;

    modport source (output valid, output instr_word, output branch_taken,
                    output divisor_zero, input ready);
    modport sink   (input valid, input instr_word, input branch_taken,
                    input divisor_zero, output ready);
endinterface

// ===== hdl/hsc_out_if.sv =====
interface hsc_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  stall_added;
    logic [1:0]  flush_added;
    logic        unsupported;
    logic [31:0] instr_total;
    logic [31:0] bubble_total;
    logic [31:0] flush_total;
    logic [31:0] cycle_total;

    modport source (output valid, output stall_added, output flush_added,
                    output unsupported, output instr_total, output bubble_total,
                    output flush_total, output cycle_total, input ready);
    modport sink   (input valid, input stall_added, input flush_added,
                    input unsupported, input instr_total, input bubble_total,
                    input flush_total, input cycle_total, output ready);
endinterface

// ===== hdl/pipeline_hazard_stall_counter.sv =====
// Each accepted beat steps through ST_CHECK (once per source, with ST_BUBBLE runs for
// stalls), ST_PUSH, ST_SUM and ST_DONE before its result beat; the history shifter inserts
// one bubble per cycle, and only one instruction is handled at a time.
// The input is ready again once the result sits in the output register.
// Reset: rst_n asynchronous active low; clears history to register 0 / stage 0,
// zeroes the instruction, bubble and flush counters and drops the result valid.
module pipeline_hazard_stall_counter import hsc_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    hsc_in_if.sink     instr,
    hsc_out_if.source  result
);

    state_t      state_reg, state_next;
    dec_t        dec_in;
    dec_t        dec_reg, dec_next;
    logic [1:0]  src_idx_reg, src_idx_next;
    logic [2:0]  bub_rem_reg, bub_rem_next;
    logic [3:0]  stall_reg, stall_next;
    logic [31:0] instr_cnt_reg, instr_cnt_next;
    logic [31:0] bubble_cnt_reg, bubble_cnt_next;
    logic [31:0] flush_cnt_reg, flush_cnt_next;
    logic [31:0] sum_reg, sum_next;

    logic        out_valid_reg, out_valid_next;
    logic [3:0]  o_stall_reg, o_stall_next;
    logic [1:0]  o_flush_reg, o_flush_next;
    logic        o_unsup_reg, o_unsup_next;
    logic [31:0] o_instr_reg, o_instr_next;
    logic [31:0] o_bubble_reg, o_bubble_next;
    logic [31:0] o_flush_tot_reg, o_flush_tot_next;
    logic [31:0] o_cycle_reg, o_cycle_next;

    reg_id_t     key;
    stage_t      need;
    logic        hit;
    stage_t      hit_stage;
    logic        push_en;
    reg_id_t     push_dest;
    stage_t      push_stage;

    hsc_decode u_decode (
        .instr_word   (instr.instr_word),
        .branch_taken (instr.branch_taken),
        .divisor_zero (instr.divisor_zero),
        .dec          (dec_in)
    );

    hsc_history #(.DEPTH(HISTORY_DEPTH)) u_history (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        (key),
        .hit        (hit),
        .hit_stage  (hit_stage),
        .push_en    (push_en),
        .push_dest  (push_dest),
        .push_stage (push_stage)
    );

    assign key  = src_idx_reg[0] ? dec_reg.src1  : dec_reg.src0;
    assign need = src_idx_reg[0] ? dec_reg.need1 : dec_reg.need0;

    assign instr.ready  = (state_reg == ST_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.stall_added  = o_stall_reg;
    assign result.flush_added  = o_flush_reg;
    assign result.unsupported  = o_unsup_reg;
    assign result.instr_total  = o_instr_reg;
    assign result.bubble_total = o_bubble_reg;
    assign result.flush_total  = o_flush_tot_reg;
    assign result.cycle_total  = o_cycle_reg;

    always_comb
    begin
        state_next       = state_reg;
        dec_next         = dec_reg;
        src_idx_next     = src_idx_reg;
        bub_rem_next     = bub_rem_reg;
        stall_next       = stall_reg;
        instr_cnt_next   = instr_cnt_reg;
        bubble_cnt_next  = bubble_cnt_reg;
        flush_cnt_next   = flush_cnt_reg;
        sum_next         = sum_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        o_stall_next     = o_stall_reg;
        o_flush_next     = o_flush_reg;
        o_unsup_next     = o_unsup_reg;
        o_instr_next     = o_instr_reg;
        o_bubble_next    = o_bubble_reg;
        o_flush_tot_next = o_flush_tot_reg;
        o_cycle_next     = o_cycle_reg;
        push_en          = 1'b0;
        push_dest        = REG_EMPTY;
        push_stage       = STG_NONE;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (instr.valid)
                begin
                    dec_next       = dec_in;
                    src_idx_next   = 2'd0;
                    stall_next     = 4'd0;
                    instr_cnt_next = instr_cnt_reg + 32'd1;
                    state_next     = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (src_idx_reg >= dec_reg.nsrc)
                    state_next = ST_PUSH;
                else if (hit && (hit_stage > need))
                begin
                    bub_rem_next = hit_stage - need;
                    stall_next   = stall_reg + {1'b0, hit_stage - need};
                    state_next   = ST_BUBBLE;
                end
                else
                    src_idx_next = src_idx_reg + 2'd1;
            end
            ST_BUBBLE:
            begin
                push_en      = 1'b1;
                bub_rem_next = bub_rem_reg - 3'd1;
                if (bub_rem_reg == 3'd1)
                begin
                    src_idx_next = src_idx_reg + 2'd1;
                    state_next   = ST_CHECK;
                end
            end
            ST_PUSH:
            begin
                push_en         = dec_reg.push;
                push_dest       = dec_reg.dest;
                push_stage      = dec_reg.ready;
                bubble_cnt_next = bubble_cnt_reg + {28'd0, stall_reg};
                flush_cnt_next  = flush_cnt_reg + {30'd0, dec_reg.flush};
                state_next      = ST_SUM;
            end
            ST_SUM:
            begin
                sum_next   = instr_cnt_reg + bubble_cnt_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next   = 1'b1;
                    o_stall_next     = stall_reg;
                    o_flush_next     = dec_reg.flush;
                    o_unsup_next     = dec_reg.unsup;
                    o_instr_next     = instr_cnt_reg;
                    o_bubble_next    = bubble_cnt_reg;
                    o_flush_tot_next = flush_cnt_reg;
                    o_cycle_next     = sum_reg + flush_cnt_reg + PIPE_FILL;
                    state_next       = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            src_idx_reg    <= 2'd0;
            bub_rem_reg    <= 3'd0;
            stall_reg      <= 4'd0;
            instr_cnt_reg  <= '0;
            bubble_cnt_reg <= '0;
            flush_cnt_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            src_idx_reg    <= src_idx_next;
            bub_rem_reg    <= bub_rem_next;
            stall_reg      <= stall_next;
            instr_cnt_reg  <= instr_cnt_next;
            bubble_cnt_reg <= bubble_cnt_next;
            flush_cnt_reg  <= flush_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dec_reg         <= dec_next;
        sum_reg         <= sum_next;
        o_stall_reg     <= o_stall_next;
        o_flush_reg     <= o_flush_next;
        o_unsup_reg     <= o_unsup_next;
        o_instr_reg     <= o_instr_next;
        o_bubble_reg    <= o_bubble_next;
        o_flush_tot_reg <= o_flush_tot_next;
        o_cycle_reg     <= o_cycle_next;
    end

endmodule

// ===== hdl/hsc_decode.sv =====
module hsc_decode import hsc_pkg::*;
(
    input  logic [31:0] instr_word,
    input  logic        branch_taken,
    input  logic        divisor_zero,
    output dec_t        dec
);

    logic [5:0] op;
    logic [5:0] funct;
    logic [3:0] code;
    reg_id_t    rs;
    reg_id_t    rt;
    reg_id_t    rd;

    assign op    = instr_word[31:26];
    assign funct = instr_word[5:0];
    assign code  = instr_word[3:0];
    assign rs    = {1'b0, instr_word[25:21]};
    assign rt    = {1'b0, instr_word[20:16]};
    assign rd    = {1'b0, instr_word[15:11]};

    always_comb
    begin
        dec       = '0;
        dec.push  = 1'b1;
        dec.dest  = REG_EMPTY;
        dec.ready = STG_NONE;
        dec.flush = FLUSH_NONE;
        unique case (op)
            OP_SPECIAL:
            begin
                unique case (funct)
                    FN_SLL, FN_SRA:
                    begin
                        dec.src0 = rs; dec.need0 = STG_EXE1; dec.nsrc = 2'd1;
                        dec.dest = rd; dec.ready = STG_EXE2;
                    end
                    FN_JR:
                    begin
                        dec.flush = FLUSH_CTL;
                        dec.src0 = rs; dec.need0 = STG_ID; dec.nsrc = 2'd1;
                    end
                    FN_MFHI, FN_MFLO:
                    begin
                        dec.src0 = REG_HILO; dec.need0 = STG_EXE1; dec.nsrc = 2'd1;
                        dec.dest = rd; dec.ready = STG_MEM2;
                    end
                    FN_MULT:
                    begin
                        dec.src0 = rs; dec.src1 = rt;
                        dec.need0 = STG_EXE1; dec.need1 = STG_EXE1; dec.nsrc = 2'd2;
                        dec.dest = REG_HILO; dec.ready = STG_MEM2;
                    end
                    FN_DIV:
                    begin
                        if (divisor_zero)
                        begin
                            dec.src0 = rt; dec.need0 = STG_EXE1; dec.nsrc = 2'd1;
                        end
                        else
                        begin
                            dec.src0 = rs; dec.src1 = rt;
                            dec.need0 = STG_EXE1; dec.need1 = STG_EXE1; dec.nsrc = 2'd2;
                            dec.dest = REG_HILO; dec.ready = STG_MEM2;
                        end
                    end
                    FN_ADDU, FN_SUBU, FN_SLT:
                    begin
                        dec.src0 = rs; dec.src1 = rt;
                        dec.need0 = STG_EXE1; dec.need1 = STG_EXE1; dec.nsrc = 2'd2;
                        dec.dest = rd; dec.ready = STG_EXE2;
                    end
                    default:
                    begin
                        dec.unsup = 1'b1; dec.push = 1'b0;
                    end
                endcase
            end
            OP_J:
                dec.flush = FLUSH_CTL;
            OP_JAL:
            begin
                dec.flush = FLUSH_CTL; dec.dest = REG_RA; dec.ready = STG_ID;
            end
            OP_BEQ, OP_BNE:
            begin
                if (branch_taken)
                    dec.flush = FLUSH_CTL;
                dec.src0 = rs; dec.src1 = rt;
                dec.need0 = STG_ID; dec.need1 = STG_ID; dec.nsrc = 2'd2;
            end
            OP_ADDIU, OP_ANDI:
            begin
                dec.src0 = rs; dec.need0 = STG_EXE1; dec.nsrc = 2'd1;
                dec.dest = rt; dec.ready = STG_EXE2;
            end
            OP_LUI:
            begin
                dec.dest = rt; dec.ready = STG_EXE2;
            end
            OP_TRAP:
            begin
                priority if (code == TRAP_PUTI)
                begin
                    dec.src0 = rs; dec.need0 = STG_EXE1; dec.nsrc = 2'd1;
                end
                else if (code == TRAP_GETI)
                begin
                    dec.dest = rt; dec.ready = STG_EXE2;
                end
                else
                begin
                    dec.push  = 1'b0;
                    dec.unsup = (code != TRAP_HALT) && (code != TRAP_NOP);
                end
            end
            OP_LW:
            begin
                dec.src0 = rs; dec.need0 = STG_EXE1; dec.nsrc = 2'd1;
                dec.dest = rt; dec.ready = STG_MEM2;
            end
            OP_SW:
            begin
                dec.src0 = rt; dec.src1 = rs;
                dec.need0 = STG_MEM2; dec.need1 = STG_MEM2; dec.nsrc = 2'd2;
            end
            default:
            begin
                dec.unsup = 1'b1; dec.push = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/hsc_history.sv =====
module hsc_history import hsc_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  reg_id_t key,
    output logic    hit,
    output stage_t  hit_stage,
    input  logic    push_en,
    input  reg_id_t push_dest,
    input  stage_t  push_stage
);

    reg_id_t dest_reg  [DEPTH];
    stage_t  stage_reg [DEPTH];
    reg_id_t dest_next [DEPTH];
    stage_t  stage_next[DEPTH];

    // youngest match wins: scan oldest first so index 0 overrides
    always_comb
    begin
        hit       = 1'b0;
        hit_stage = STG_NONE;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (dest_reg[i] == key)
            begin
                hit       = 1'b1;
                hit_stage = stage_reg[i];
            end
        end
    end

    // shared shift unit: age every ready stage (saturating), then shift
    always_comb
    begin
        dest_next[0]  = push_dest;
        stage_next[0] = push_stage;
        for (int i = 1; i < DEPTH; i++)
        begin
            dest_next[i]  = dest_reg[i-1];
            stage_next[i] = (stage_reg[i-1] != STG_NONE) ? stage_reg[i-1] - 3'd1
                                                         : STG_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                dest_reg[i]  <= '0;
                stage_reg[i] <= STG_NONE;
            end
        end
        else if (push_en)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                dest_reg[i]  <= dest_next[i];
                stage_reg[i] <= stage_next[i];
            end
        end
    end

endmodule

// ===== hdl/hsc_checker.sv =====
module hsc_checker import hsc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  stall_added,
    input logic [1:0]  flush_added,
    input logic        unsupported,
    input logic [31:0] instr_total,
    input logic [31:0] bubble_total,
    input logic [31:0] flush_total,
    input logic [31:0] cycle_total
);

    // one instruction in flight: no second beat right after an accepted one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after an accepted beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(instr_total))
        else $error("result beat dropped or changed while stalled");

    a_stall_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> stall_added <= 4'd8
                      && (flush_added == FLUSH_NONE || flush_added == FLUSH_CTL))
        else $error("stall or flush count out of range");

    a_unsup_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unsupported |-> stall_added == 4'd0 && flush_added == FLUSH_NONE)
        else $error("unsupported instruction added stalls or flushes");

    a_cycle_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cycle_total == instr_total + bubble_total + flush_total + PIPE_FILL)
        else $error("cycle total inconsistent with the other totals");

endmodule

bind pipeline_hazard_stall_counter hsc_checker u_hsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (instr.valid),
    .in_ready     (instr.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .stall_added  (result.stall_added),
    .flush_added  (result.flush_added),
    .unsupported  (result.unsupported),
    .instr_total  (result.instr_total),
    .bubble_total (result.bubble_total),
    .flush_total  (result.flush_total),
    .cycle_total  (result.cycle_total)
);
